>>> src/r2e_pkg.sv
// ----------------------------------------------------------------------------
// r2e_pkg: shared types and constants for rotation matrix to Euler angles
// Payload structs, the CORDIC arctangent table and fixed-point limits.
// ----------------------------------------------------------------------------
package r2e_pkg;

    localparam int CordicStepsDef = 16;
    localparam int AtanLen        = 24;
    localparam int ZW             = 32;   // angle accumulator, Q.24
    localparam int XW             = 36;   // CORDIC vector width
    localparam int AW             = 17;   // atan2 argument width
    localparam int SqW            = 30;   // square root datapath width
    localparam int SqSteps        = 15;   // result bits of the root
    localparam int LimW           = 15;

    localparam logic signed [ZW-1:0] PiQ24    = 32'sd52707179;
    localparam logic signed [15:0]   AngleMax = 16'sd25736;
    localparam logic signed [16:0]   OneQ14   = 17'sd16384;

    localparam logic [LimW-1:0] LockXyzRst = 15'd0;
    localparam logic [LimW-1:0] LockZxyRst = 15'd8;

    typedef enum logic { REG_LOCK_XYZ = 1'b0, REG_LOCK_ZXY = 1'b1 } t_reg_idx;
    typedef enum logic { MODE_XYZ = 1'b0, MODE_ZXY = 1'b1 } t_mode;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m22;
    } t_in;

    typedef struct packed {
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        logic               gimbal_lock;
    } t_out;

    typedef struct packed {
        logic mode;
        logic lock;
    } t_tag;

    function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        unique case (i)
            5'd0:    r = 32'sd13176795;
            5'd1:    r = 32'sd7778716;
            5'd2:    r = 32'sd4110060;
            5'd3:    r = 32'sd2086331;
            5'd4:    r = 32'sd1047214;
            5'd5:    r = 32'sd524117;
            5'd6:    r = 32'sd262123;
            5'd7:    r = 32'sd131069;
            5'd8:    r = 32'sd65536;
            5'd9:    r = 32'sd32768;
            5'd10:   r = 32'sd16384;
            5'd11:   r = 32'sd8192;
            5'd12:   r = 32'sd4096;
            5'd13:   r = 32'sd2048;
            5'd14:   r = 32'sd1024;
            5'd15:   r = 32'sd512;
            5'd16:   r = 32'sd256;
            5'd17:   r = 32'sd128;
            5'd18:   r = 32'sd64;
            5'd19:   r = 32'sd32;
            5'd20:   r = 32'sd16;
            5'd21:   r = 32'sd8;
            5'd22:   r = 32'sd4;
            5'd23:   r = 32'sd2;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> src/r2e_cordic.sv
// ----------------------------------------------------------------------------
// r2e_cordic: pipelined atan2 in vectoring mode
// One stage per rotation; result rounded to Q3.13 and saturated.
// ----------------------------------------------------------------------------
module r2e_cordic
    import r2e_pkg::*;
#(
    parameter int STEPS = CordicStepsDef
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [AW-1:0] i_y,
    input  logic signed [AW-1:0] i_x,
    input  t_tag                 i_tag,
    output logic signed [15:0]   o_ang,
    output t_tag                 o_tag
);

    logic signed [XW-1:0] r_x [0:STEPS];
    logic signed [XW-1:0] r_y [0:STEPS];
    logic signed [ZW-1:0] r_z [0:STEPS];
    logic                 r_zf [0:STEPS];
    t_tag                 r_t [0:STEPS];
    logic signed [15:0]   r_ang;
    t_tag                 r_tag;

    logic signed [AW-1:0] n_xa, n_ya;
    logic signed [ZW-1:0] n_z0;
    logic signed [ZW-1:0] n_zr;
    logic signed [15:0]   n_ang;

    always_comb begin
        n_xa = i_x;
        n_ya = i_y;
        n_z0 = '0;
        if (i_y == '0) begin
            n_z0 = (i_x < 0) ? PiQ24 : '0;
        end else if (i_x < 0) begin
            // turn the vector by pi into the right half plane
            n_xa = -i_x;
            n_ya = -i_y;
            n_z0 = (i_y > 0) ? PiQ24 : -PiQ24;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]  <= XW'(n_xa) <<< 16;
            r_y[0]  <= XW'(n_ya) <<< 16;
            r_z[0]  <= n_z0;
            r_zf[0] <= (i_y == '0);
            r_t[0]  <= i_tag;
        end
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zf[g+1] <= r_zf[g];
                r_t[g+1]  <= r_t[g];
                if (r_zf[g]) begin
                    r_x[g+1] <= r_x[g];
                    r_y[g+1] <= r_y[g];
                    r_z[g+1] <= r_z[g];
                end else if (r_y[g] >= 0) begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_q24(5'(g));
                end else begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_q24(5'(g));
                end
            end
        end
    end

    // Q.24 to Q3.13, round half up
    always_comb begin
        n_zr = (r_z[STEPS] + ZW'(1024)) >>> 11;
        if (n_zr > ZW'(AngleMax)) begin
            n_ang = AngleMax;
        end else if (n_zr < -ZW'(AngleMax)) begin
            n_ang = -AngleMax;
        end else begin
            n_ang = n_zr[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang <= n_ang;
            r_tag <= r_t[STEPS];
        end
    end

    assign o_ang = r_ang;
    assign o_tag = r_tag;

endmodule

>>> src/rotation_matrix_to_euler_angles.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_angles: Euler angles from a Q2.14 rotation matrix
// Integer square root pipeline feeding three pipelined CORDIC atan2 units.
// ----------------------------------------------------------------------------
//  channel  signals                          dir  notes
//  input    i_valid / o_ready / i_data       in   t_in, one matrix per item
//  output   o_valid / i_ready / o_data       out  t_out, one result per item
//  config   i_cfg_we / i_cfg_addr / i_cfg_data in  lock limits, no read-back
//
//  One item per cycle unless the output stalls; stages: input reg, square,
//  15 root stages, CORDIC_STEPS + 2 CORDIC stages, output reg.
//  The whole pipeline advances together; a stalled output freezes it, and
//  no new item is taken until it advances again. Reset clears the valids.
module rotation_matrix_to_euler_angles
    import r2e_pkg::*;
#(
    parameter int CORDIC_STEPS = CordicStepsDef
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  t_in             i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output t_out            o_data,
    input  logic            i_cfg_we,
    input  logic            i_cfg_addr,
    input  logic [LimW-1:0] i_cfg_data
);

    localparam int Lat = CORDIC_STEPS + 20;

    logic            en;
    logic            r_vld [0:Lat-1];
    logic [LimW-1:0] r_lim_xyz, r_lim_zxy;

    t_in                  r_in, r_q;
    logic signed [AW-1:0] r_qs;
    logic [SqW-1:0]       r_qv;
    logic signed [AW-1:0] n_s;

    logic [SqW-1:0]       r_sv [0:SqSteps-1];
    logic [SqW-1:0]       r_sr [0:SqSteps-1];
    t_in                  r_sp [0:SqSteps-1];
    logic signed [AW-1:0] r_ss [0:SqSteps-1];

    t_in                  p;
    logic [LimW-1:0]      c;
    logic                 n_lock;
    t_tag                 n_tag, w_tag;
    logic signed [AW-1:0] n_by, n_bx, n_cy, n_cx;
    logic signed [15:0]   w_a, w_b, w_c;
    t_out                 r_out, n_out;

    assign en      = !r_vld[Lat-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[Lat-1];
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_xyz <= LockXyzRst;
            r_lim_zxy <= LockZxyRst;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_LOCK_XYZ: r_lim_xyz <= i_cfg_data;
                REG_LOCK_ZXY: r_lim_zxy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < Lat; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < Lat; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // saturate the sine term, then 1 - s^2 in Q.28
    always_comb begin
        n_s = AW'(r_in.mode ? r_in.m12 : r_in.m02);
        if (n_s > OneQ14) n_s = OneQ14;
        if (n_s < -OneQ14) n_s = -OneQ14;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in <= i_data;
            r_q  <= r_in;
            r_qs <= n_s;
            r_qv <= SqW'(29'd268435456) - SqW'(unsigned'(34'(n_s * n_s)));
        end
    end

    // digit-by-digit root, one result bit per stage
    for (genvar g = 0; g < SqSteps; g++) begin : g_sqrt
        localparam logic [SqW-1:0] Bit = SqW'(1) << (2 * (SqSteps - 1 - g));
        logic [SqW-1:0] v_in, r_in_s;
        t_in            p_in;
        logic signed [AW-1:0] s_in;
        if (g == 0) begin : g_first
            assign v_in   = r_qv;
            assign r_in_s = '0;
            assign p_in   = r_q;
            assign s_in   = r_qs;
        end else begin : g_next
            assign v_in   = r_sv[g-1];
            assign r_in_s = r_sr[g-1];
            assign p_in   = r_sp[g-1];
            assign s_in   = r_ss[g-1];
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sp[g] <= p_in;
                r_ss[g] <= s_in;
                if (v_in >= r_in_s + Bit) begin
                    r_sv[g] <= v_in - (r_in_s + Bit);
                    r_sr[g] <= (r_in_s >> 1) + Bit;
                end else begin
                    r_sv[g] <= v_in;
                    r_sr[g] <= r_in_s >> 1;
                end
            end
        end
    end

    // lock decision and argument selection for the three units
    always_comb begin
        p      = r_sp[SqSteps-1];
        c      = r_sr[SqSteps-1][LimW-1:0];
        n_lock = p.mode ? (c <= r_lim_zxy) : (c <= r_lim_xyz);
        n_tag  = '{mode: p.mode, lock: n_lock};
        if (p.mode == MODE_XYZ) begin
            n_by = -AW'(p.m12);
            n_bx = AW'(p.m22);
            n_cy = n_lock ? AW'(p.m10) : -AW'(p.m01);
            n_cx = n_lock ? AW'(p.m11) : AW'(p.m00);
        end else begin
            n_by = n_lock ? AW'(p.m20) : -AW'(p.m02);
            n_bx = n_lock ? AW'(p.m00) : AW'(p.m22);
            n_cy = -AW'(p.m10);
            n_cx = AW'(p.m11);
        end
    end

    r2e_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_a (
        .i_clk(i_clk), .i_en(en), .i_y(r_ss[SqSteps-1]),
        .i_x(AW'(c)), .i_tag(n_tag), .o_ang(w_a), .o_tag(w_tag)
    );
    r2e_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_b (
        .i_clk(i_clk), .i_en(en), .i_y(n_by), .i_x(n_bx),
        .i_tag(n_tag), .o_ang(w_b), .o_tag()
    );
    r2e_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_c (
        .i_clk(i_clk), .i_en(en), .i_y(n_cy), .i_x(n_cx),
        .i_tag(n_tag), .o_ang(w_c), .o_tag()
    );

    always_comb begin
        n_out.gimbal_lock = w_tag.lock;
        if (w_tag.mode == MODE_XYZ) begin
            n_out.angle_x = w_tag.lock ? 16'sd0 : -w_b;
            n_out.angle_y = -w_a;
            n_out.angle_z = -w_c;
        end else begin
            n_out.angle_x = w_a;
            n_out.angle_y = w_b;
            n_out.angle_z = w_tag.lock ? 16'sd0 : w_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_out <= n_out;
    end

    a_lock_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.gimbal_lock |->
            (o_data.angle_x == 16'sd0 || o_data.angle_z == 16'sd0))
        else $error("lock result without a zeroed angle");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.angle_y <= AngleMax && o_data.angle_y >= -AngleMax))
        else $error("angle out of range");

    a_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[SqSteps+1] |-> (r_sr[SqSteps-1] <= SqW'(16384)))
        else $error("cosine above one");

endmodule
